// File: hdl/idea_pkg.sv
// shared types, constants and the modulo 65537 multiply for the idea cipher
// no dependencies
package idea_pkg;

  localparam int WORD_W = 16;
  localparam int REG_W  = 64;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_KEY_UPPER = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_KEY_LOWER = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DECRYPT   = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t block_word_a;
    word_t block_word_b;
    word_t block_word_c;
    word_t block_word_d;
  } in_block_t;

  typedef struct packed {
    word_t result_word_a;
    word_t result_word_b;
    word_t result_word_c;
    word_t result_word_d;
  } out_block_t;

  typedef enum logic [1:0] {
    BS_READY,
    BS_BUILD,
    BS_INVERT
  } build_state_t;

  typedef enum logic [1:0] {
    OP_COPY,
    OP_NEG,
    OP_INV
  } key_op_t;

  // multiply modulo 65537, zero stands for 65536
  function automatic word_t idea_mul(input word_t a, input word_t b);
    logic [2*WORD_W-1:0] prod;
    word_t lo;
    word_t hi;
    word_t res;
    prod = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
    lo   = prod[WORD_W-1:0];
    hi   = prod[2*WORD_W-1:WORD_W];
    if (a == '0) begin
      res = word_t'(1) - b;
    end else if (b == '0) begin
      res = word_t'(1) - a;
    end else begin
      res = lo - hi;
      if (lo < hi) begin
        res = res + word_t'(1);
      end
    end
    return res;
  endfunction

endpackage

// File: hdl/idea_block_cipher_top.sv
// IDEA cipher top level: key schedule sequencer, subkey registers, round pipeline
// depends on idea_pkg
//
// One 64-bit block is accepted per clock whenever busy is low; its result shows
// on out_block with out_valid high for one cycle, after the input register, the
// three register stages of each round (the first multiply and adds, the middle
// multiply, the last multiply with the mixing) and the output register.
// The receiver cannot stall. After reset and after every configuration write
// the block holds busy high while the subkeys are rebuilt; for decryption the
// rebuild also computes the 2*ROUND_COUNT+2 modular inverses, done in turn by
// one square-and-multiply unit.
module idea_block_cipher_top #(
  parameter int ROUND_COUNT = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  idea_pkg::in_block_t                 in_block,
  output logic                                out_valid,
  output idea_pkg::out_block_t                out_block,
  input  logic                                cfg_we,
  input  logic [idea_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [idea_pkg::REG_W-1:0]          cfg_wdata
);

  localparam int RND   = (ROUND_COUNT > 8) ? 8 : ((ROUND_COUNT < 1) ? 1 : ROUND_COUNT);
  localparam int NKEYS = 6 * RND + 4;
  localparam int IW    = $clog2(NKEYS);

  // configuration registers
  logic [idea_pkg::REG_W-1:0] key_upper_r;
  logic [idea_pkg::REG_W-1:0] key_lower_r;
  logic                       decrypt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
      decrypt_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        idea_pkg::CFG_KEY_UPPER: key_upper_r <= cfg_wdata;
        idea_pkg::CFG_KEY_LOWER: key_lower_r <= cfg_wdata;
        idea_pkg::CFG_DECRYPT:   decrypt_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- key schedule ----------------
  logic [127:0] key_full;
  logic [127:0] rot_w [8];
  assign key_full = {key_upper_r, key_lower_r};

  // each group of eight subkeys comes from the key rotated left by 25 more bits
  for (genvar g = 0; g < 8; g++) begin : g_rot
    localparam int AMT = (25 * g) % 128;
    if (AMT == 0) begin : g_none
      assign rot_w[g] = key_full;
    end else begin : g_some
      logic [255:0] dbl;
      assign dbl = {key_full, key_full};
      assign rot_w[g] = dbl[255-AMT -: 128];
    end
  end

  idea_pkg::build_state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [2:0]    pos_r, pos_nxt;
  logic [IW-1:0] sb_r, sb_nxt;
  idea_pkg::word_t inv_base_r, inv_base_nxt;
  idea_pkg::word_t inv_acc_r, inv_acc_nxt;
  logic [3:0]    inv_cnt_r, inv_cnt_nxt;

  logic [IW-1:0]   src_idx;
  logic            first_last;
  idea_pkg::word_t src_word;
  idea_pkg::key_op_t op;
  idea_pkg::word_t acc_step;
  idea_pkg::word_t base_step;
  logic            wr_en;
  idea_pkg::word_t wr_data;
  logic [2:0]      grp;
  logic [2:0]      wsel;
  logic [127:0]    rot_sel;
  logic [6:0]      bitpos;

  idea_pkg::word_t sk_r [NKEYS];

  assign first_last = (idx_r < IW'(6)) || (sb_r == '0);

  always_comb begin
    src_idx = idx_r;
    op      = idea_pkg::OP_COPY;
    if (decrypt_r) begin
      case (pos_r)
        3'd0: begin src_idx = sb_r;                                op = idea_pkg::OP_INV; end
        3'd1: begin src_idx = sb_r + (first_last ? IW'(1) : IW'(2)); op = idea_pkg::OP_NEG; end
        3'd2: begin src_idx = sb_r + (first_last ? IW'(2) : IW'(1)); op = idea_pkg::OP_NEG; end
        3'd3: begin src_idx = sb_r + IW'(3);                       op = idea_pkg::OP_INV; end
        3'd4: src_idx = sb_r - IW'(2);
        default: src_idx = sb_r - IW'(1);
      endcase
    end
  end

  assign grp     = 3'(src_idx >> 3);
  assign wsel    = src_idx[2:0];
  assign rot_sel = rot_w[grp];
  assign bitpos  = {3'd7 - wsel, 4'd0};
  assign src_word = rot_sel[bitpos +: 16];

  assign acc_step  = idea_pkg::idea_mul(inv_acc_r, inv_base_r);
  assign base_step = idea_pkg::idea_mul(inv_base_r, inv_base_r);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    sb_nxt       = sb_r;
    inv_base_nxt = inv_base_r;
    inv_acc_nxt  = inv_acc_r;
    inv_cnt_nxt  = inv_cnt_r;
    wr_en        = 1'b0;
    wr_data      = src_word;
    unique case (state_r)
      idea_pkg::BS_READY: ;
      idea_pkg::BS_BUILD: begin
        if (op == idea_pkg::OP_INV) begin
          inv_base_nxt = src_word;
          inv_acc_nxt  = idea_pkg::word_t'(1);
          inv_cnt_nxt  = '0;
          state_nxt    = idea_pkg::BS_INVERT;
        end else begin
          wr_en   = 1'b1;
          wr_data = (op == idea_pkg::OP_NEG) ? idea_pkg::word_t'(0) - src_word : src_word;
        end
      end
      idea_pkg::BS_INVERT: begin
        inv_acc_nxt  = acc_step;
        inv_base_nxt = base_step;
        inv_cnt_nxt  = inv_cnt_r + 4'd1;
        if (inv_cnt_r == 4'd15) begin
          wr_en     = 1'b1;
          wr_data   = acc_step;
          state_nxt = idea_pkg::BS_BUILD;
        end
      end
      default: state_nxt = idea_pkg::BS_READY;
    endcase
    if (wr_en) begin
      if (idx_r == IW'(NKEYS - 1)) begin
        state_nxt = idea_pkg::BS_READY;
      end else begin
        idx_nxt = idx_r + IW'(1);
        if (pos_r == 3'd5) begin
          pos_nxt = '0;
          sb_nxt  = sb_r - IW'(6);
        end else begin
          pos_nxt = pos_r + 3'd1;
        end
      end
    end
    // any register write restarts the schedule
    if (cfg_we) begin
      state_nxt = idea_pkg::BS_BUILD;
      idx_nxt   = '0;
      pos_nxt   = '0;
      sb_nxt    = IW'(6 * RND);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= idea_pkg::BS_BUILD;
      idx_r     <= '0;
      pos_r     <= '0;
      sb_r      <= IW'(6 * RND);
      inv_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      pos_r     <= pos_nxt;
      sb_r      <= sb_nxt;
      inv_cnt_r <= inv_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inv_base_r <= inv_base_nxt;
    inv_acc_r  <= inv_acc_nxt;
    if (wr_en && rst_n) begin
      sk_r[idx_r] <= wr_data;
    end
  end

  assign busy = (state_r != idea_pkg::BS_READY);

  // ---------------- round pipeline ----------------
  idea_pkg::word_t cx_r [RND+1][4];
  logic            cv_r [RND+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else begin
      cv_r[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cx_r[0][0] <= in_block.block_word_a;
    cx_r[0][1] <= in_block.block_word_b;
    cx_r[0][2] <= in_block.block_word_c;
    cx_r[0][3] <= in_block.block_word_d;
  end

  for (genvar r = 0; r < RND; r++) begin : g_round
    idea_pkg::word_t ax_r [4];
    idea_pkg::word_t bx_r [4];
    idea_pkg::word_t kk_r;
    idea_pkg::word_t t1;
    idea_pkg::word_t t2;
    logic av_r, bv_r;

    assign t1 = idea_pkg::idea_mul(sk_r[6*r+5], kk_r + (bx_r[1] ^ bx_r[3]));
    assign t2 = kk_r + t1;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        av_r      <= 1'b0;
        bv_r      <= 1'b0;
        cv_r[r+1] <= 1'b0;
      end else begin
        av_r      <= cv_r[r];
        bv_r      <= av_r;
        cv_r[r+1] <= bv_r;
      end
    end

    always_ff @(posedge clk) begin
      ax_r[0] <= idea_pkg::idea_mul(cx_r[r][0], sk_r[6*r]);
      ax_r[1] <= cx_r[r][1] + sk_r[6*r+1];
      ax_r[2] <= cx_r[r][2] + sk_r[6*r+2];
      ax_r[3] <= idea_pkg::idea_mul(cx_r[r][3], sk_r[6*r+3]);
      bx_r    <= ax_r;
      kk_r    <= idea_pkg::idea_mul(sk_r[6*r+4], ax_r[0] ^ ax_r[2]);
      cx_r[r+1][0] <= bx_r[0] ^ t1;
      cx_r[r+1][1] <= bx_r[2] ^ t1;
      cx_r[r+1][2] <= bx_r[1] ^ t2;
      cx_r[r+1][3] <= bx_r[3] ^ t2;
    end
  end

  // output transformation
  logic out_valid_r;
  idea_pkg::out_block_t out_block_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cv_r[RND];
    end
  end

  always_ff @(posedge clk) begin
    out_block_r.result_word_a <= idea_pkg::idea_mul(cx_r[RND][0], sk_r[6*RND]);
    out_block_r.result_word_b <= cx_r[RND][2] + sk_r[6*RND+1];
    out_block_r.result_word_c <= cx_r[RND][1] + sk_r[6*RND+2];
    out_block_r.result_word_d <= idea_pkg::idea_mul(cx_r[RND][3], sk_r[6*RND+3]);
  end

  assign out_valid = out_valid_r;
  assign out_block = out_block_r;

endmodule

// File: hdl/idea_checker.sv
// port-level checker for the idea cipher top level, with its bind
// depends on idea_pkg and idea_block_cipher_top
module idea_checker #(
  parameter int ROUND_COUNT = 8
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic                        cfg_we,
  input logic [idea_pkg::CFG_IW-1:0] cfg_index
);

  localparam int RND = (ROUND_COUNT > 8) ? 8 : ((ROUND_COUNT < 1) ? 1 : ROUND_COUNT);
  localparam int LAT = 3 * RND + 2;

  // every request comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request did not produce a result on time");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  // a register write starts a schedule rebuild
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == idea_pkg::CFG_KEY_UPPER || cfg_index == idea_pkg::CFG_KEY_LOWER
      || cfg_index == idea_pkg::CFG_DECRYPT)) |=> busy)
    else $error("no rebuild after register write");

endmodule

bind idea_block_cipher_top idea_checker #(.ROUND_COUNT(ROUND_COUNT)) u_idea_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);

// File: tb/tb_idea_block_cipher_top.sv
// self-checking testbench for idea_block_cipher_top: block requests under several keys
// and both modes, results checked against an in-bench IDEA model; depends on idea_pkg
`timescale 1ns / 100ps

module tb_idea_block_cipher_top;

  localparam int NROUNDS = 8;
  localparam int NKEYS = 6 * NROUNDS + 4;
  localparam int DRAIN_CYCLES = 3 * NROUNDS + 8;
  localparam logic [idea_pkg::CFG_IW-1:0] CFG_UNUSED = 2'd3;
  localparam int NPHASES = 10;
  localparam int ITEMS_PER_PHASE = 110;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  idea_pkg::in_block_t in_block = '0;
  logic out_valid;
  idea_pkg::out_block_t out_block;
  logic cfg_we = 1'b0;
  logic [idea_pkg::CFG_IW-1:0] cfg_index = idea_pkg::CFG_KEY_UPPER;
  logic [idea_pkg::REG_W-1:0] cfg_wdata = '0;

  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic decrypt_q;
  idea_pkg::word_t subkeys[NKEYS];
  idea_pkg::out_block_t pending_blocks[$];
  int err_count = 0;

  idea_block_cipher_top #(.ROUND_COUNT(NROUNDS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_block(in_block),
    .out_valid(out_valid), .out_block(out_block),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    #2ms;
    $display("idea_block_cipher_top regression: fail");
    $finish;
  end

  function automatic idea_pkg::word_t mul65537(idea_pkg::word_t a, idea_pkg::word_t b);
    longint unsigned x;
    longint unsigned y;
    x = (a == 0) ? 65536 : a;
    y = (b == 0) ? 65536 : b;
    return idea_pkg::word_t'((x * y) % 65537);
  endfunction

  function automatic idea_pkg::word_t inv65537(idea_pkg::word_t v);
    longint unsigned base;
    longint unsigned acc;
    int unsigned e;
    base = (v == 0) ? 65536 : v;
    acc = 1;
    e = 65535;
    while (e != 0) begin
      if (e & 1) acc = (acc * base) % 65537;
      base = (base * base) % 65537;
      e = e >> 1;
    end
    return idea_pkg::word_t'(acc);
  endfunction

  function automatic void rebuild_subkeys();
    idea_pkg::word_t fwd[NKEYS];
    logic [127:0] k;
    int s;
    k = {key_hi_q, key_lo_q};
    for (int i = 0; i < NKEYS; i++) begin
      if (i % 8 == 0 && i != 0) k = {k[102:0], k[127:103]};
      fwd[i] = k[127 - 16 * (i % 8) -: 16];
    end
    if (!decrypt_q) begin
      foreach (fwd[i]) subkeys[i] = fwd[i];
      return;
    end
    foreach (subkeys[i]) subkeys[i] = '0;
    for (int i = 0; i <= NROUNDS; i++) begin
      s = 6 * (NROUNDS - i);
      subkeys[6*i]   = inv65537(fwd[s]);
      subkeys[6*i+3] = inv65537(fwd[s+3]);
      // outer rounds keep the add key order, inner ones swap it
      if (i == 0 || i == NROUNDS) begin
        subkeys[6*i+1] = -fwd[s+1];
        subkeys[6*i+2] = -fwd[s+2];
      end else begin
        subkeys[6*i+1] = -fwd[s+2];
        subkeys[6*i+2] = -fwd[s+1];
      end
      if (i < NROUNDS) begin
        subkeys[6*i+4] = fwd[6*(NROUNDS-1-i)+4];
        subkeys[6*i+5] = fwd[6*(NROUNDS-1-i)+5];
      end
    end
  endfunction

  function automatic idea_pkg::out_block_t idea_process(idea_pkg::in_block_t blk);
    idea_pkg::word_t x1, x2, x3, x4, kk, t1, t2, sw;
    idea_pkg::out_block_t res;
    x1 = blk.block_word_a;
    x2 = blk.block_word_b;
    x3 = blk.block_word_c;
    x4 = blk.block_word_d;
    for (int r = 0; r < NROUNDS; r++) begin
      x1 = mul65537(x1, subkeys[6*r]);
      x4 = mul65537(x4, subkeys[6*r+3]);
      x2 = x2 + subkeys[6*r+1];
      x3 = x3 + subkeys[6*r+2];
      kk = mul65537(subkeys[6*r+4], x1 ^ x3);
      t1 = mul65537(subkeys[6*r+5], kk + (x2 ^ x4));
      t2 = kk + t1;
      x1 = x1 ^ t1;
      x4 = x4 ^ t2;
      sw = x2 ^ t2;
      x2 = x3 ^ t1;
      x3 = sw;
    end
    res.result_word_a = mul65537(x1, subkeys[6*NROUNDS]);
    res.result_word_b = x3 + subkeys[6*NROUNDS+1];
    res.result_word_c = x2 + subkeys[6*NROUNDS+2];
    res.result_word_d = mul65537(x4, subkeys[6*NROUNDS+3]);
    return res;
  endfunction

  // results are strobed, so check on every edge where out_valid was high
  always @(posedge clk) begin
    idea_pkg::out_block_t want;
    if (rst_n && out_valid) begin
      if (pending_blocks.size() == 0) begin
        $error("unexpected result %h", out_block);
        err_count++;
      end else begin
        want = pending_blocks.pop_front();
        if (out_block.result_word_a !== want.result_word_a) begin
          $error("result_word_a exp %h got %h", want.result_word_a, out_block.result_word_a);
          err_count++;
        end
        if (out_block.result_word_b !== want.result_word_b) begin
          $error("result_word_b exp %h got %h", want.result_word_b, out_block.result_word_b);
          err_count++;
        end
        if (out_block.result_word_c !== want.result_word_c) begin
          $error("result_word_c exp %h got %h", want.result_word_c, out_block.result_word_c);
          err_count++;
        end
        if (out_block.result_word_d !== want.result_word_d) begin
          $error("result_word_d exp %h got %h", want.result_word_d, out_block.result_word_d);
          err_count++;
        end
      end
    end
  end

  task automatic send_block(idea_pkg::in_block_t blk, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_block <= blk;
    do @(posedge clk); while (busy);
    pending_blocks.push_back(idea_process(blk));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [idea_pkg::CFG_IW-1:0] idx,
                           logic [idea_pkg::REG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (idx)
      idea_pkg::CFG_KEY_UPPER: key_hi_q = data;
      idea_pkg::CFG_KEY_LOWER: key_lo_q = data;
      idea_pkg::CFG_DECRYPT:   decrypt_q = data[0];
      default: return;
    endcase
    rebuild_subkeys();
  endtask

  function automatic idea_pkg::word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return idea_pkg::word_t'($urandom);
    endcase
  endfunction

  idea_pkg::in_block_t directed_blocks[14] = '{
    64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 64'h0001_0001_0001_0001,
    64'h8000_8000_8000_8000, 64'h0000_ffff_0000_ffff, 64'hffff_0000_ffff_0000,
    64'h0000_0001_0002_0003, 64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h7fff_8000_7fff_8000,
    64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210
  };

  initial begin
    logic [63:0] hi, lo;
    logic burst;
    int gap;
    key_hi_q = '0;
    key_lo_q = '0;
    decrypt_q = 1'b0;
    rebuild_subkeys();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed requests on the all-zero reset key
    foreach (directed_blocks[i]) send_block(directed_blocks[i], i % 3);
    burst = 1'b0;
    for (int p = 0; p < NPHASES; p++) begin
      drain_results();
      case (p)
        0: begin hi = 64'h0001_0002_0003_0004; lo = 64'h0005_0006_0007_0008; end
        1: begin hi = 64'h0001_0002_0003_0004; lo = 64'h0005_0006_0007_0008; end
        2: begin hi = '1; lo = '1; end
        3: begin hi = '1; lo = '1; end
        4: begin hi = '0; lo = '0; end
        default: begin
          hi = {$urandom, $urandom};
          lo = {$urandom, $urandom};
        end
      endcase
      if (p == 1) write_reg(CFG_UNUSED, {$urandom, $urandom});
      write_reg(idea_pkg::CFG_KEY_UPPER, hi);
      write_reg(idea_pkg::CFG_KEY_LOWER, lo);
      write_reg(idea_pkg::CFG_DECRYPT, {63'($urandom), p[0]});
      if (p < 2) begin
        foreach (directed_blocks[i]) send_block(directed_blocks[i], 0);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 19) == 0) burst = ~burst;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (p == 3 && n == 50) begin
          // hold requests back until the pipeline has emptied
          start <= 1'b0;
          while (pending_blocks.size() != 0) @(posedge clk);
          gap = 0;
        end
        send_block({rand_word(), rand_word(), rand_word(), rand_word()}, gap);
      end
    end
    drain_results();
    if (err_count == 0) begin
      $display("idea_block_cipher_top regression: pass");
    end else begin
      $display("idea_block_cipher_top regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/idea_pkg.sv
hdl/idea_block_cipher_top.sv
hdl/idea_checker.sv
tb/tb_idea_block_cipher_top.sv
